// ----- rtl/core/dqp_pkg.sv -----
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types and constants for the DNS question-section parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dqp_pkg;

    // Longest name (characters plus dots) that is passed on
    localparam int MAX_NAME_BYTES = 255;
    localparam int NAME_LEN_W     = $clog2(MAX_NAME_BYTES + 1);

    localparam int HDR_BYTES = 12;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_CHAR   = 2'd1,
        KIND_QEND   = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_TRUNCATED = 2'd0,
        ERR_LABEL_LEN = 2'd1,
        ERR_NAME_LONG = 2'd2
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] message_id;
        logic [15:0] header_flags;
        logic [15:0] question_count;
        logic [15:0] answer_count;
        logic [15:0] authority_count;
        logic [15:0] additional_count;
        logic [7:0]  name_char;
        logic [15:0] query_type;
        logic [15:0] query_class;
        t_err        error_code;
        logic        last_of_run;
    } t_result;

    // What one parsed byte produces: an optional main result and an
    // optional trailing truncation error
    typedef struct packed {
        logic    main_valid;
        t_result main;
        logic    trunc;
    } t_step;

    localparam t_result TRUNC_RESULT = '{
        kind:             KIND_ERROR,
        message_id:       16'h0000,
        header_flags:     16'h0000,
        question_count:   16'h0000,
        answer_count:     16'h0000,
        authority_count:  16'h0000,
        additional_count: 16'h0000,
        name_char:        8'h00,
        query_type:       16'h0000,
        query_class:      16'h0000,
        error_code:       ERR_TRUNCATED,
        last_of_run:      1'b1
    };

endpackage

`default_nettype wire

// ----- rtl/core/dqp_parser.sv -----
// ----------------------------------------------------------------------------
// dqp_parser
// Parse state and per-byte decode: header, question name, qtype/qclass.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    output dqp_pkg::t_step     o_step
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_QTAIL,
        PH_DONE,
        PH_FAILED
    } t_phase;

    localparam int HdrStore = dqp_pkg::HDR_BYTES - 1;

    t_phase                          r_phase, n_phase;
    logic [3:0]                      r_pos, n_pos;
    logic [5:0]                      r_lab, n_lab;
    logic                            r_first, n_first;
    logic [dqp_pkg::NAME_LEN_W-1:0]  r_len, n_len;
    logic [15:0]                     r_type, n_type;
    logic [7:0]                      r_class_hi, n_class_hi;
    logic [7:0]                      r_hdr [0:HdrStore-1];

    dqp_pkg::t_result res;
    logic             main_valid;
    logic             had_err;
    logic             trunc;
    logic             name_full;

    assign name_full = r_len >= dqp_pkg::NAME_LEN_W'(dqp_pkg::MAX_NAME_BYTES);

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_lab      = r_lab;
        n_first    = r_first;
        n_len      = r_len;
        n_type     = r_type;
        n_class_hi = r_class_hi;
        res        = '0;
        main_valid = 1'b0;
        had_err    = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_pos == 4'(HdrStore)) begin
                    main_valid           = 1'b1;
                    res.kind             = dqp_pkg::KIND_HEADER;
                    res.message_id       = {r_hdr[0], r_hdr[1]};
                    res.header_flags     = {r_hdr[2], r_hdr[3]};
                    res.question_count   = {r_hdr[4], r_hdr[5]};
                    res.answer_count     = {r_hdr[6], r_hdr[7]};
                    res.authority_count  = {r_hdr[8], r_hdr[9]};
                    res.additional_count = {r_hdr[10], i_byte};
                    n_phase              = PH_NAME;
                    n_pos                = '0;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end
            PH_NAME: begin
                priority if (r_lab != '0) begin
                    if (name_full) begin
                        main_valid     = 1'b1;
                        had_err        = 1'b1;
                        res.kind       = dqp_pkg::KIND_ERROR;
                        res.error_code = dqp_pkg::ERR_NAME_LONG;
                        n_phase        = PH_FAILED;
                    end else begin
                        main_valid    = 1'b1;
                        res.kind      = dqp_pkg::KIND_CHAR;
                        res.name_char = i_byte;
                        n_len         = r_len + dqp_pkg::NAME_LEN_W'(1);
                        n_lab         = r_lab - 6'd1;
                    end
                end else if (i_byte == 8'd0) begin
                    n_phase = PH_QTAIL;
                    n_pos   = '0;
                end else if (i_byte[7:6] != 2'b00) begin
                    // length 64 or more, compression pointers included
                    main_valid     = 1'b1;
                    had_err        = 1'b1;
                    res.kind       = dqp_pkg::KIND_ERROR;
                    res.error_code = dqp_pkg::ERR_LABEL_LEN;
                    n_phase        = PH_FAILED;
                end else if (!r_first && name_full) begin
                    main_valid     = 1'b1;
                    had_err        = 1'b1;
                    res.kind       = dqp_pkg::KIND_ERROR;
                    res.error_code = dqp_pkg::ERR_NAME_LONG;
                    n_phase        = PH_FAILED;
                end else begin
                    if (!r_first) begin
                        main_valid    = 1'b1;
                        res.kind      = dqp_pkg::KIND_CHAR;
                        res.name_char = 8'h2E;
                        n_len         = r_len + dqp_pkg::NAME_LEN_W'(1);
                    end
                    n_first = 1'b0;
                    n_lab   = i_byte[5:0];
                end
            end
            PH_QTAIL: begin
                unique case (r_pos)
                    4'd0:    n_type     = {i_byte, 8'h00};
                    4'd1:    n_type     = {r_type[15:8], i_byte};
                    4'd2:    n_class_hi = i_byte;
                    default: begin
                        main_valid      = 1'b1;
                        res.kind        = dqp_pkg::KIND_QEND;
                        res.query_type  = r_type;
                        res.query_class = {r_class_hi, i_byte};
                        n_phase         = PH_DONE;
                    end
                endcase
                n_pos = r_pos + 4'd1;
            end
            PH_FAILED: had_err = 1'b1;
            default: ;
        endcase

        trunc = i_last && !had_err && (n_phase != PH_DONE) && (n_phase != PH_FAILED);
        res.last_of_run = !trunc;

        // final byte returns everything to the start of a datagram
        if (i_last) begin
            n_phase    = PH_HEADER;
            n_pos      = '0;
            n_lab      = '0;
            n_first    = 1'b1;
            n_len      = '0;
            n_type     = '0;
            n_class_hi = '0;
        end
    end

    assign o_step = '{main_valid: main_valid, main: res, trunc: trunc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_lab   <= '0;
            r_first <= 1'b1;
            r_len   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_lab   <= n_lab;
            r_first <= n_first;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_type     <= n_type;
            r_class_hi <= n_class_hi;
            if (r_phase == PH_HEADER && r_pos < 4'(HdrStore)) begin
                r_hdr[r_pos] <= i_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dns_query_wire_parser.sv -----
// ----------------------------------------------------------------------------
// dns_query_wire_parser
// Byte-stream DNS question parser: header words, name characters,
// qtype/qclass and error reports.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------
//  in       | to block  | i_in_valid / o_in_stall    | i_data_byte, i_end_of_datagram
//  out      | from block| o_out_valid / i_out_stall  | o_result_kind .. o_last_of_run
//
// One byte per cycle while the input is not stalled; a taken byte is registered,
// then parsed into the result register, from which its result transfers.
// A byte that gives two results (a result plus the truncation error on the
// final byte) holds the input while the result register drains.
// Bytes that give no result pass even while the output is stalled.
// Reset is synchronous and returns the parser to the start of a datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_query_wire_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_datagram,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic [15:0]      o_message_id,
    output logic [15:0]      o_header_flags,
    output logic [15:0]      o_question_count,
    output logic [15:0]      o_answer_count,
    output logic [15:0]      o_authority_count,
    output logic [15:0]      o_additional_count,
    output logic [7:0]       o_name_char,
    output logic [15:0]      o_query_type,
    output logic [15:0]      o_query_class,
    output logic [1:0]       o_error_code,
    output logic             o_last_of_run
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    logic             r_out_valid;
    dqp_pkg::t_result r_out;
    logic             r_trunc_pend;

    dqp_pkg::t_step   step;
    logic             has_res;
    logic             out_take;
    logic             slot_free;
    logic             parse_fire;
    logic             in_take;

    dqp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (parse_fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_step  (step)
    );

    assign has_res    = step.main_valid | step.trunc;
    assign out_take   = r_out_valid & ~i_out_stall;
    assign slot_free  = (~r_out_valid | out_take) & ~r_trunc_pend;
    assign parse_fire = r_in_valid & (slot_free | ~has_res);
    assign o_in_stall = r_in_valid & ~parse_fire;
    assign in_take    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_trunc_pend <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (parse_fire) begin
                r_in_valid <= 1'b0;
            end

            if (parse_fire && has_res) begin
                r_out_valid  <= 1'b1;
                r_trunc_pend <= step.main_valid & step.trunc;
            end else if (out_take) begin
                // a pending truncation error takes the slot next
                r_out_valid  <= r_trunc_pend;
                r_trunc_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_end_of_datagram;
        end
        if (parse_fire && has_res) begin
            r_out <= step.main_valid ? step.main : dqp_pkg::TRUNC_RESULT;
        end else if (out_take && r_trunc_pend) begin
            r_out <= dqp_pkg::TRUNC_RESULT;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_out.kind;
    assign o_message_id       = r_out.message_id;
    assign o_header_flags     = r_out.header_flags;
    assign o_question_count   = r_out.question_count;
    assign o_answer_count     = r_out.answer_count;
    assign o_authority_count  = r_out.authority_count;
    assign o_additional_count = r_out.additional_count;
    assign o_name_char        = r_out.name_char;
    assign o_query_type       = r_out.query_type;
    assign o_query_class      = r_out.query_class;
    assign o_error_code       = r_out.error_code;
    assign o_last_of_run      = r_out.last_of_run;

endmodule

`default_nettype wire

// ----- rtl/core/dqp_checker.sv -----
// ----------------------------------------------------------------------------
// dqp_checker
// Port-level checks for the DNS question parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_result_kind,
    input wire logic [1:0]  o_error_code,
    input wire logic [7:0]  o_name_char,
    input wire logic        o_last_of_run
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_kind)
            && $stable(o_name_char) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // a result that is not last of its run is followed at once by the truncation error
    a_trunc_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_run |=>
            o_out_valid && o_result_kind == dqp_pkg::KIND_ERROR
            && o_error_code == dqp_pkg::ERR_TRUNCATED && o_last_of_run)
        else $error("truncation error missing after non-final result");

    // errors always close a run
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == dqp_pkg::KIND_ERROR |-> o_last_of_run)
        else $error("error result not last of run");

    // unused error code never shows
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == dqp_pkg::KIND_ERROR |-> o_error_code != 2'd3)
        else $error("bad error code");

endmodule

bind dns_query_wire_parser dqp_checker u_dqp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_kind (o_result_kind),
    .o_error_code  (o_error_code),
    .o_name_char   (o_name_char),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire
